FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is high
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked assertion that also holds during reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

FILE: rtl/dcqs_pkg.sv
// ============================================================================
// dcqs_pkg
// constants, types and crc helpers for the daisy-chain query sequencer
// ============================================================================
package dcqs_pkg;

   localparam int CHAIN_SLOTS = 9;

   localparam int PRE_W = 10;
   localparam int POS_W = 11;
   localparam int CW    = POS_W + 1;

   localparam logic [PRE_W-1:0] PREAMBLE_RESET = 10'd430;
   localparam logic [CW-1:0]    FRAME_LEN      = CW'(5);
   localparam logic [CW-1:0]    SLOT_BYTES     = CW'(4 * CHAIN_SLOTS);

   localparam logic [7:0] FRAME_HEAD = 8'h0F;
   localparam logic [7:0] FILL_BYTE  = 8'hFF;
   localparam logic [7:0] TAIL_BYTE  = 8'hF0;

   // operation codes
   localparam logic OP_START    = 1'b0;
   localparam logic OP_EXCHANGE = 1'b1;

   // register word index (byte address bit 2)
   localparam logic REG_PREAMBLE = 1'b0;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        done_res;
      logic        found;
      logic [31:0] response_word;
      logic        rejected;
   } result_type;

   function automatic logic [3:0] crc_nibble(input logic [3:0] idx);
      logic [3:0] r;
      case (idx)
         4'h0: r = 4'h0;
         4'h1: r = 4'h9;
         4'h2: r = 4'hB;
         4'h3: r = 4'h2;
         4'h4: r = 4'hF;
         4'h5: r = 4'h6;
         4'h6: r = 4'h4;
         4'h7: r = 4'hD;
         4'h8: r = 4'h7;
         4'h9: r = 4'hE;
         4'hA: r = 4'hC;
         4'hB: r = 4'h5;
         4'hC: r = 4'h8;
         4'hD: r = 4'h1;
         4'hE: r = 4'h3;
         4'hF: r = 4'hA;
         default: r = 4'h0;
      endcase
      return r;
   endfunction

   // low nibble first, then high nibble
   function automatic logic [3:0] crc_byte(input logic [3:0] crc, input logic [7:0] b);
      logic [3:0] c;
      c = crc_nibble(crc ^ b[3:0]);
      c = crc_nibble(c ^ b[7:4]);
      return c;
   endfunction

endpackage

FILE: rtl/daisy_chain_query_sequencer_top.sv
// ============================================================================
// daisy_chain_query_sequencer_top
// sequencer for one query on a daisy-chained serial bus
// ============================================================================
//
//   channel   direction  handshake                 carries
//   req_      in         req_valid / req_ready     start or byte-exchange word
//   rsp_      out        rsp_valid / rsp_ready     next tx byte, done, response
//   csr_      in/out     apb, pready tied high     preamble_length at 0x0
//
// every request word is handled in the cycle it is accepted and its result
// lands in the response register at that edge
// a new request is taken every cycle while the response register is empty or
// being drained; the only thing that stops intake is a stalled response
// reset (synchronous, active high) drops any query in flight and restores the
// preamble length to 430
// ============================================================================
module daisy_chain_query_sequencer_top (
   input  logic        clock,
   input  logic        reset,

   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_target_id,
   input  logic [3:0]  req_command_code,
   input  logic [15:0] req_data_word,
   input  logic [7:0]  req_rx_byte,

   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_done_res,
   output logic        rsp_found,
   output logic [31:0] rsp_response_word,
   output logic        rsp_rejected,

   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dcqs_pkg::*;

   logic [PRE_W-1:0] preamble_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff;
   result_type       result;
   logic             fire;
   logic             csr_write;

   // apb register: word index is address bit 2
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_PREAMBLE)
                       ? {{(32-PRE_W){1'b0}}, preamble_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff <= PREAMBLE_RESET;
      end else if (csr_write && csr_paddr[2] == REG_PREAMBLE) begin
         preamble_ff <= csr_pwdata[PRE_W-1:0];
      end
   end

   // intake runs whenever the response register is free or emptying
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;

   dcqs_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .operation       (req_operation),
      .target_id       (req_target_id),
      .command_code    (req_command_code),
      .data_word       (req_data_word),
      .rx_byte         (req_rx_byte),
      .preamble_length (preamble_ff),
      .result          (result)
   );

   // response register: loads on each accepted word, holds while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_valid      = rsp_data_ff.tx_valid;
   assign rsp_tx_byte       = rsp_data_ff.tx_byte;
   assign rsp_done_res      = rsp_data_ff.done_res;
   assign rsp_found         = rsp_data_ff.found;
   assign rsp_response_word = rsp_data_ff.response_word;
   assign rsp_rejected      = rsp_data_ff.rejected;

endmodule

FILE: rtl/dcqs_frame.sv
// ============================================================================
// dcqs_frame
// builds the five-byte command frame with its nibble crc
// ============================================================================
module dcqs_frame (
   input  logic [7:0]  target_id,
   input  logic [3:0]  command_code,
   input  logic [15:0] data_word,
   output logic [39:0] frame
);
   import dcqs_pkg::*;

   logic [7:0] b0;
   logic [7:0] b1;
   logic [7:0] b2;
   logic [3:0] crc;

   always_comb begin
      b0  = {data_word[3:0], 4'h0};
      b1  = data_word[11:4];
      b2  = {command_code, data_word[15:12]};
      crc = crc_byte(4'h0, b0);
      crc = crc_byte(crc, b1);
      crc = crc_byte(crc, b2);
      crc = crc_byte(crc, target_id);
      // frame[7:0], the head byte, goes out first; b0 with the crc goes out last
      frame = {b0 | {4'h0, crc}, b1, b2, target_id, FRAME_HEAD};
   end

endmodule

FILE: rtl/dcqs_engine.sv
// ============================================================================
// dcqs_engine
// query state, byte schedule and slot matching; one fired word per cycle
// ============================================================================
module dcqs_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  logic                      operation,
   input  logic [7:0]                target_id,
   input  logic [3:0]                command_code,
   input  logic [15:0]               data_word,
   input  logic [7:0]                rx_byte,
   input  logic [dcqs_pkg::PRE_W-1:0] preamble_length,
   output dcqs_pkg::result_type      result
);
   import dcqs_pkg::*;

   logic             busy_ff,     busy_in;
   logic [POS_W-1:0] pos_ff,      pos_in;
   logic [39:0]      frame_ff,    frame_in;
   logic [7:0]       qid_ff,      qid_in;
   logic [31:0]      capture_ff,  capture_in;
   logic             match_ff,    match_in;
   logic [31:0]      matched_ff,  matched_in;

   logic [39:0]   frame_new;
   logic [CW-1:0] pre_ext;
   logic [CW-1:0] slot_start;
   logic [CW-1:0] total_len;
   logic [CW-1:0] pos_ext;
   logic [CW-1:0] slot_off;
   logic [CW-1:0] next_pos;
   logic          in_slots;

   function automatic logic [7:0] byte_at(
      input logic [CW-1:0] pos,
      input logic [CW-1:0] pre,
      input logic [39:0]   frm
   );
      logic [CW-1:0] off;
      logic [7:0]    r;
      off = pos - pre;
      if (pos < pre) begin
         r = 8'h00;
      end else if (pos < pre + FRAME_LEN) begin
         case (off[2:0])
            3'd0:    r = frm[7:0];
            3'd1:    r = frm[15:8];
            3'd2:    r = frm[23:16];
            3'd3:    r = frm[31:24];
            3'd4:    r = frm[39:32];
            default: r = 8'h00;
         endcase
      end else if (pos < pre + FRAME_LEN + SLOT_BYTES) begin
         r = FILL_BYTE;
      end else begin
         r = TAIL_BYTE;
      end
      return r;
   endfunction

   dcqs_frame u_frame (
      .target_id    (target_id),
      .command_code (command_code),
      .data_word    (data_word),
      .frame        (frame_new)
   );

   always_comb begin
      pre_ext    = {{(CW-PRE_W){1'b0}}, preamble_length};
      slot_start = pre_ext + FRAME_LEN;
      total_len  = slot_start + SLOT_BYTES + CW'(1);
      pos_ext    = {1'b0, pos_ff};
      slot_off   = pos_ext - slot_start;
      in_slots   = (pos_ext >= slot_start) && (slot_off < SLOT_BYTES);
      next_pos   = pos_ext + CW'(1);

      busy_in    = busy_ff;
      pos_in     = pos_ff;
      frame_in   = frame_ff;
      qid_in     = qid_ff;
      capture_in = capture_ff;
      match_in   = match_ff;
      matched_in = matched_ff;
      result     = '0;

      if (operation == OP_START) begin
         if (busy_ff) begin
            result.rejected = 1'b1;
         end else begin
            frame_in       = frame_new;
            qid_in         = target_id;
            busy_in        = 1'b1;
            pos_in         = '0;
            capture_in     = '0;
            match_in       = 1'b0;
            matched_in     = '0;
            result.tx_valid = 1'b1;
            result.tx_byte  = byte_at('0, pre_ext, frame_new);
         end
      end else if (!busy_ff) begin
         result.rejected = 1'b1;
      end else begin
         if (in_slots) begin
            capture_in = {capture_ff[23:0], rx_byte};
            // slot complete: second byte of the slot carries the device id
            if (slot_off[1:0] == 2'd3 && !match_ff && capture_in[23:16] == qid_ff) begin
               match_in   = 1'b1;
               matched_in = capture_in;
            end
         end
         if (next_pos >= total_len) begin
            busy_in              = 1'b0;
            pos_in               = '0;
            result.done_res      = 1'b1;
            result.found         = match_in;
            result.response_word = match_in ? matched_in : 32'h0;
         end else begin
            pos_in          = next_pos[POS_W-1:0];
            result.tx_valid = 1'b1;
            result.tx_byte  = byte_at(next_pos, pre_ext, frame_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pos_ff   <= '0;
         match_ff <= 1'b0;
      end else if (fire) begin
         busy_ff  <= busy_in;
         pos_ff   <= pos_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         frame_ff   <= frame_in;
         qid_ff     <= qid_in;
         capture_ff <= capture_in;
         matched_ff <= matched_in;
      end
   end

endmodule

FILE: rtl/dcqs_checker.sv
// ============================================================================
// dcqs_checker
// port-level checks on the query sequencer, bound to the top level
// ============================================================================
`include "assert_macros.svh"

module dcqs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_tx_valid,
   input logic [7:0]  rsp_tx_byte,
   input logic        rsp_done_res,
   input logic        rsp_found,
   input logic [31:0] rsp_response_word,
   input logic        rsp_rejected
);

   property p_rsp_hold;
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_response_word);
   endproperty

   property p_reject_clean;
      rsp_valid && rsp_rejected |->
         !rsp_tx_valid && !rsp_done_res && !rsp_found && rsp_response_word == 32'h0;
   endproperty

   property p_done_excl;
      rsp_valid |-> !(rsp_tx_valid && rsp_done_res) && (rsp_done_res || !rsp_found);
   endproperty

   // no response word survives reset
   `CHK_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "response valid after reset")

   // a stalled response word holds
   `CHK_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "stalled response changed")

   // a rejected word carries nothing else
   `CHK_ASSERT(a_reject_clean, clock, reset, p_reject_clean, "rejected word not clean")

   // done and a byte to send never come together; found only with done
   `CHK_ASSERT(a_done_excl, clock, reset, p_done_excl, "done or found inconsistent")

endmodule

bind daisy_chain_query_sequencer_top dcqs_checker u_dcqs_checker (.*);
